// File: hw/rtl/spft_pkg.sv
// Package for the serial port frame timing block.
// Holds register addresses, control bit positions and divider widths.
// No dependencies.
package spft_pkg;

    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 32;

    localparam logic [7:0] ADDR_PCON = 8'h87;
    localparam logic [7:0] ADDR_TCON = 8'h88;
    localparam logic [7:0] ADDR_TMOD = 8'h89;
    localparam logic [7:0] ADDR_TL1  = 8'h8B;
    localparam logic [7:0] ADDR_TH1  = 8'h8D;
    localparam logic [7:0] ADDR_SCON = 8'h98;
    localparam logic [7:0] ADDR_SBUF = 8'h99;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_RXQ   = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    // bit positions in SCON, PCON and TCON
    localparam int SCON_MODE_HI = 7;
    localparam int SCON_MODE_LO = 6;
    localparam int SCON_MULTI   = 5;
    localparam int SCON_RXEN    = 4;
    localparam int SCON_TXBIT9  = 3;
    localparam int SCON_RXBIT9  = 2;
    localparam int SCON_TI      = 1;
    localparam int SCON_RI      = 0;
    localparam int PCON_DOUBLE  = 7;
    localparam int TCON_RUN1    = 6;

endpackage

// File: hw/rtl/spft_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on spft_pkg for operand widths.
module spft_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [spft_pkg::DIV_NUM_W-1:0]   num,
    input  logic [spft_pkg::DIV_DEN_W-1:0]   den,
    output logic                             done,
    output logic [spft_pkg::DIV_NUM_W-1:0]   quot
);
    localparam int CNT_W = $clog2(spft_pkg::DIV_NUM_W + 1);

    logic [spft_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [spft_pkg::DIV_NUM_W-1:0] quot_reg;
    logic [spft_pkg::DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [spft_pkg::DIV_DEN_W:0]   trial;
    logic [spft_pkg::DIV_DEN_W:0]   diff;
    logic                           ge;

    assign trial = {rem_reg, quot_reg[spft_pkg::DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quot_reg <= num;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(spft_pkg::DIV_NUM_W);
            end else if (busy_reg) begin
                // shift in the next numerator bit, subtract when it fits
                if (ge) begin
                    rem_reg <= diff[spft_pkg::DIV_DEN_W-1:0];
                end else begin
                    rem_reg <= trial[spft_pkg::DIV_DEN_W-1:0];
                end
                quot_reg <= {quot_reg[spft_pkg::DIV_NUM_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: hw/rtl/serial_port_frame_timing_core.sv
// Top level of the serial port frame timing block: bus sequencer and state.
// Depends on spft_pkg and spft_div.
module serial_port_frame_timing_core #(
    parameter logic [31:0] OSC_HZ_RESET = 32'd11059200,
    parameter logic [31:0] CPS_RESET    = 32'd921600
) (
    // Serial port of an 8051-style core at frame level.
    // s_ channel: one beat per event (register write, register read, queued
    // receive frame, time tick). m_ channel: exactly one result beat per event.
    // cfg_we/cfg_addr/cfg_wdata write osc_hz (0) and cycles_per_sec (1).
    // Path of an event: reads, unknown writes, frame queueing and ticks on an
    // inactive port go straight to the result stage. Writes to the timing
    // registers and SBUF pass the baud pick, then the 33-step shared divider
    // when mode 2 has a nonzero osc_hz/64 rate or modes 1 and 3 run from
    // timer 1, and then the commit. Ticks on a live port step through the
    // transmit bit times while a transmit runs, then the receive countdown.
    // One event is in flight at a time; s_tready is high only while the
    // sequencer is idle, and it accepts the next beat while a result still
    // waits in the output register.
    // Reset clears all SFRs and timing state and loads the oscillator and
    // machine rate defaults. When the receiver stalls, the finished result
    // holds in the output register and the sequencer waits for it.
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], reg_addr[9:2], write_data[17:10], rx_byte[25:18],
    // rx_ninth[26], tick_cycles[42:27], zero fill above
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], rx_accepted[8], tx_done[9], tx_data[17:10],
    // tx_ninth[18], baud[50:19], baud_changed[51], overrun[52], zero fill
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    typedef enum logic [2:0] {
        S_IDLE, S_BAUD, S_DIV, S_COMMIT, S_TX, S_RX, S_DONE
    } state_t;

    state_t state_reg;

    logic [31:0] osc_hz_reg, cps_reg;
    logic [7:0]  scon_reg, pcon_reg, tcon_reg, tmod_reg, tl1_reg, th1_reg, sbuf_reg;
    logic [15:0] bit_period_reg;
    logic [31:0] baud_now_reg;
    logic        tx_busy_reg, tx_held_ninth_reg;
    logic [7:0]  tx_held_byte_reg;
    logic [3:0]  tx_bits_left_reg;
    logic [17:0] bit_accum_reg;
    logic [18:0] tx_work_reg;
    logic        rx_waiting_reg, rx_held_ninth_reg;
    logic [7:0]  rx_held_byte_reg;
    logic [19:0] rx_countdown_reg;
    logic        overrun_reg;

    // latched event
    logic [15:0] cyc_reg;
    logic        sbuf_wr_reg;
    logic        mode2_reg;
    logic [31:0] baud_new_reg;
    logic [15:0] period_new_reg;

    // result fields
    logic [7:0]  rd_reg, td_reg;
    logic        acc_reg, done_reg, t9_reg, chg_reg;
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    // input unpack
    logic [1:0]  in_func;
    logic [7:0]  in_addr, in_wd, in_rb;
    logic        in_r9;
    logic [15:0] in_cyc;
    assign in_func = s_tdata[1:0];
    assign in_addr = s_tdata[9:2];
    assign in_wd   = s_tdata[17:10];
    assign in_rb   = s_tdata[25:18];
    assign in_r9   = s_tdata[26];
    assign in_cyc  = s_tdata[42:27];

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // mode decode and shared divider operands
    logic        sm0, sm1, smod;
    logic [26:0] b_mode2;
    logic [13:0] c_full, c_mode1;
    logic [19:0] frame_cycles;
    logic [3:0]  frame_bits;
    assign sm0     = scon_reg[spft_pkg::SCON_MODE_HI];
    assign sm1     = scon_reg[spft_pkg::SCON_MODE_LO];
    assign smod    = pcon_reg[spft_pkg::PCON_DOUBLE];
    assign b_mode2 = smod ? {osc_hz_reg[31:6], 1'b0} : {1'b0, osc_hz_reg[31:6]};
    assign c_full  = {14'(9'd256 - {1'b0, th1_reg})} << 5;
    assign c_mode1 = smod ? (c_full >> 1) : c_full;
    assign frame_bits = sm0 ? 4'd11 : 4'd10;
    // period times 10 or 11 as shift-add
    assign frame_cycles = ({4'b0, bit_period_reg} << 3) + ({4'b0, bit_period_reg} << 1)
                        + (sm0 ? {4'b0, bit_period_reg} : 20'd0);

    logic                            div_start, div_done;
    logic [spft_pkg::DIV_NUM_W-1:0]  div_num, div_quot;
    logic [spft_pkg::DIV_DEN_W-1:0]  div_den;

    always_comb begin
        div_start = 1'b0;
        div_num   = {1'b0, cps_reg};
        div_den   = 32'(c_mode1);
        if (state_reg == S_BAUD) begin
            if (sm0 && !sm1) begin
                div_start = (b_mode2 != 27'd0);
                div_num = 33'({1'b0, cps_reg} + {6'b0, b_mode2} - 33'd1);
                div_den = 32'(b_mode2);
            end else if (sm1 && tcon_reg[spft_pkg::TCON_RUN1]) begin
                div_start = 1'b1;
            end
        end
    end

    spft_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // transmit bit step and receive countdown
    logic        tx_ge;
    logic [19:0] rx_cd_next;
    assign tx_ge      = tx_work_reg >= {3'b0, bit_period_reg};
    assign rx_cd_next = (rx_countdown_reg > {4'b0, cyc_reg})
                      ? rx_countdown_reg - {4'b0, cyc_reg} : 20'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            osc_hz_reg <= OSC_HZ_RESET;
            cps_reg <= CPS_RESET;
            scon_reg <= '0; pcon_reg <= '0; tcon_reg <= '0; tmod_reg <= '0;
            tl1_reg <= '0; th1_reg <= '0; sbuf_reg <= '0;
            bit_period_reg <= '0;
            baud_now_reg <= '0;
            tx_busy_reg <= 1'b0;
            tx_held_byte_reg <= '0;
            tx_held_ninth_reg <= 1'b0;
            tx_bits_left_reg <= '0;
            bit_accum_reg <= '0;
            tx_work_reg <= '0;
            rx_waiting_reg <= 1'b0;
            rx_held_byte_reg <= '0;
            rx_held_ninth_reg <= 1'b0;
            rx_countdown_reg <= '0;
            overrun_reg <= 1'b0;
            cyc_reg <= '0;
            sbuf_wr_reg <= 1'b0;
            mode2_reg <= 1'b0;
            baud_new_reg <= '0;
            period_new_reg <= '0;
            rd_reg <= '0; td_reg <= '0;
            acc_reg <= 1'b0; done_reg <= 1'b0; t9_reg <= 1'b0; chg_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr) cps_reg <= cfg_wdata;
                else          osc_hz_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        rd_reg <= '0; td_reg <= '0;
                        acc_reg <= 1'b0; done_reg <= 1'b0; t9_reg <= 1'b0;
                        chg_reg <= 1'b0;
                        sbuf_wr_reg <= 1'b0;
                        cyc_reg <= in_cyc;
                        state_reg <= S_DONE;
                        case (in_func)
                            spft_pkg::FUNC_WRITE: begin
                                state_reg <= S_BAUD;
                                case (in_addr)
                                    spft_pkg::ADDR_SCON: scon_reg <= in_wd;
                                    spft_pkg::ADDR_PCON: pcon_reg <= in_wd;
                                    spft_pkg::ADDR_TCON: tcon_reg <= in_wd;
                                    spft_pkg::ADDR_TMOD: tmod_reg <= in_wd;
                                    spft_pkg::ADDR_TL1:  tl1_reg <= in_wd;
                                    spft_pkg::ADDR_TH1:  th1_reg <= in_wd;
                                    spft_pkg::ADDR_SBUF: begin
                                        sbuf_wr_reg <= 1'b1;
                                        sbuf_reg <= in_wd;
                                        tx_held_byte_reg <= in_wd;
                                        tx_held_ninth_reg <=
                                            scon_reg[spft_pkg::SCON_TXBIT9];
                                        scon_reg[spft_pkg::SCON_TI] <= 1'b0;
                                    end
                                    default: state_reg <= S_DONE;
                                endcase
                            end
                            spft_pkg::FUNC_READ: begin
                                case (in_addr)
                                    spft_pkg::ADDR_SCON: rd_reg <= scon_reg;
                                    spft_pkg::ADDR_PCON: rd_reg <= pcon_reg;
                                    spft_pkg::ADDR_TCON: rd_reg <= tcon_reg;
                                    spft_pkg::ADDR_TMOD: rd_reg <= tmod_reg;
                                    spft_pkg::ADDR_TL1:  rd_reg <= tl1_reg;
                                    spft_pkg::ADDR_TH1:  rd_reg <= th1_reg;
                                    spft_pkg::ADDR_SBUF: rd_reg <= sbuf_reg;
                                    default:             rd_reg <= '0;
                                endcase
                            end
                            spft_pkg::FUNC_RXQ: begin
                                // refuse while inactive; collide if one is pending
                                if (bit_period_reg != 16'd0) begin
                                    if (rx_waiting_reg) begin
                                        overrun_reg <= 1'b1;
                                    end else begin
                                        rx_waiting_reg <= 1'b1;
                                        rx_held_byte_reg <= in_rb;
                                        rx_held_ninth_reg <= in_r9;
                                        rx_countdown_reg <= frame_cycles;
                                        acc_reg <= 1'b1;
                                    end
                                end
                            end
                            spft_pkg::FUNC_TICK: begin
                                if (bit_period_reg != 16'd0) begin
                                    // drop a pending frame when the receiver is off
                                    if (!scon_reg[spft_pkg::SCON_RXEN]) begin
                                        rx_waiting_reg <= 1'b0;
                                    end
                                    tx_work_reg <= {1'b0, bit_accum_reg} + {3'b0, in_cyc};
                                    state_reg <= tx_busy_reg ? S_TX : S_RX;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_BAUD: begin
                    // pick the baud source; the divider starts from comb logic
                    mode2_reg <= sm0 && !sm1;
                    baud_new_reg <= '0;
                    period_new_reg <= '0;
                    if (sm0 && !sm1) begin
                        baud_new_reg <= 32'(b_mode2);
                        state_reg <= (b_mode2 != 27'd0) ? S_DIV : S_COMMIT;
                    end else if (sm1 && tcon_reg[spft_pkg::TCON_RUN1]) begin
                        period_new_reg <= 16'(c_mode1);
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (mode2_reg) begin
                            // saturate the rounded-up period, never zero
                            if (div_quot > 33'd65535)    period_new_reg <= 16'hFFFF;
                            else if (div_quot == 33'd0)  period_new_reg <= 16'd1;
                            else                         period_new_reg <= div_quot[15:0];
                        end else begin
                            baud_new_reg <= div_quot[31:0];
                        end
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    chg_reg <= (baud_new_reg != baud_now_reg);
                    baud_now_reg <= baud_new_reg;
                    bit_period_reg <= period_new_reg;
                    if (sbuf_wr_reg && period_new_reg != 16'd0) begin
                        tx_busy_reg <= 1'b1;
                        tx_bits_left_reg <= frame_bits;
                        bit_accum_reg <= '0;
                    end
                    state_reg <= S_DONE;
                end
                S_TX: begin
                    // advance one bit time per cycle while the accumulator covers it
                    if (tx_ge && tx_bits_left_reg != 4'd0) begin
                        tx_work_reg <= tx_work_reg - {3'b0, bit_period_reg};
                        tx_bits_left_reg <= tx_bits_left_reg - 4'd1;
                        if (tx_bits_left_reg == 4'd1) begin
                            tx_busy_reg <= 1'b0;
                            scon_reg[spft_pkg::SCON_TI] <= 1'b1;
                            done_reg <= 1'b1;
                            td_reg <= tx_held_byte_reg;
                            t9_reg <= tx_held_ninth_reg;
                        end
                    end else begin
                        bit_accum_reg <= tx_work_reg[17:0];
                        state_reg <= S_RX;
                    end
                end
                S_RX: begin
                    if (rx_waiting_reg) begin
                        rx_countdown_reg <= rx_cd_next;
                        if (rx_cd_next == 20'd0) begin
                            rx_waiting_reg <= 1'b0;
                            if (!(scon_reg[spft_pkg::SCON_MULTI] && !rx_held_ninth_reg)) begin
                                if (scon_reg[spft_pkg::SCON_RI]) begin
                                    overrun_reg <= 1'b1;
                                end else begin
                                    scon_reg[spft_pkg::SCON_RXBIT9] <= rx_held_ninth_reg;
                                    scon_reg[spft_pkg::SCON_RI] <= 1'b1;
                                    sbuf_reg <= rx_held_byte_reg;
                                end
                            end
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {3'b0, overrun_reg, chg_reg, baud_now_reg, t9_reg,
                                        td_reg, done_reg, acc_reg, rd_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_tx_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_busy_reg |-> tx_bits_left_reg != 4'd0)
        else $error("transmit busy with no bits left");
    a_rx_cd: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_waiting_reg |-> rx_countdown_reg != 20'd0)
        else $error("receive pending with expired countdown");
    a_baud_period: assert property (@(posedge aclk) disable iff (!aresetn)
        baud_now_reg != 32'd0 |-> bit_period_reg != 16'd0)
        else $error("nonzero baud on inactive port");
    a_tx_active: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(tx_busy_reg) |-> bit_period_reg != 16'd0)
        else $error("transmit started on inactive port");

endmodule

// File: tb/serial_port_frame_timing_core_tb.sv
// Self-checking testbench for serial_port_frame_timing_core: directed and random bus,
// frame and tick events against a built-in prediction of the serial port.
// Depends on spft_pkg and the block's RTL only.
module serial_port_frame_timing_core_tb;

    // Input beat layout, lowest field last.
    typedef struct packed {
        logic [4:0]  fill;
        logic [15:0] tick_cycles;
        logic        rx_ninth;
        logic [7:0]  rx_byte;
        logic [7:0]  write_data;
        logic [7:0]  reg_addr;
        logic [1:0]  func;
    } event_beat_t;

    // Result beat layout, lowest field last.
    typedef struct packed {
        logic [2:0]  fill;
        logic        overrun_flag;
        logic        baud_changed;
        logic [31:0] baud;
        logic        tx_ninth;
        logic [7:0]  tx_data;
        logic        tx_done;
        logic        rx_accepted;
        logic [7:0]  read_data;
    } port_result_t;

    localparam logic CFG_OSC_HZ = 1'b0;
    localparam logic CFG_CPS    = 1'b1;

    // Serial port state mirror plus the queue of results it predicts.
    class serial_scoreboard;
        logic [31:0] osc_hz, cps;
        logic [7:0]  scon, pcon, tcon, tmod, tl1, th1, sbuf;
        logic [31:0] period, baud_now;
        logic        tx_busy, tx_ninth, rx_waiting, rx_ninth, overrun;
        logic [7:0]  tx_byte, rx_byte;
        logic [31:0] tx_bits_left, accum, rx_countdown;
        port_result_t pending_results[$];
        int mismatches, results_checked, tx_frames, rx_frames;

        function new();
            osc_hz = 32'd11059200;
            cps    = 32'd921600;
            {scon, pcon, tcon, tmod, tl1, th1, sbuf} = '0;
            period = 0; baud_now = 0;
            tx_busy = 0; tx_ninth = 0; rx_waiting = 0; rx_ninth = 0; overrun = 0;
            tx_byte = 0; rx_byte = 0;
            tx_bits_left = 0; accum = 0; rx_countdown = 0;
            mismatches = 0; results_checked = 0; tx_frames = 0; rx_frames = 0;
        endfunction

        function logic [31:0] frame_bits();
            return scon[spft_pkg::SCON_MODE_HI] ? 32'd11 : 32'd10;
        endfunction

        // Recompute bit period and baud; return 1 when the baud moved.
        function logic retime();
            logic [31:0] prev, b, c;
            logic [63:0] p;
            prev = baud_now;
            baud_now = 0;
            period = 0;
            if (scon[spft_pkg::SCON_MODE_HI] && !scon[spft_pkg::SCON_MODE_LO]) begin
                b = osc_hz / 32'd64;
                if (pcon[spft_pkg::PCON_DOUBLE]) b = b * 32'd2;
                if (b != 0) begin
                    p = ({32'd0, cps} + {32'd0, b} - 64'd1) / {32'd0, b};
                    if (p == 0) p = 1;
                    if (p > 64'd65535) p = 64'd65535;
                    baud_now = b;
                    period = p[31:0];
                end
            end else if (scon[spft_pkg::SCON_MODE_LO]) begin
                if (tcon[spft_pkg::TCON_RUN1]) begin
                    c = (32'd256 - {24'd0, th1}) << 5;
                    if (pcon[spft_pkg::PCON_DOUBLE]) c = c >> 1;
                    if (c == 0) c = 1;
                    period = c;
                    baud_now = cps / c;
                end
            end
            return baud_now != prev;
        endfunction

        // Advance the port by one accepted event and queue its result.
        function void note_beat(event_beat_t ev);
            port_result_t r;
            logic upd;
            r = '0;
            case (ev.func)
                spft_pkg::FUNC_WRITE: begin
                    upd = 1;
                    case (ev.reg_addr)
                        spft_pkg::ADDR_SCON: scon = ev.write_data;
                        spft_pkg::ADDR_PCON: pcon = ev.write_data;
                        spft_pkg::ADDR_TCON: tcon = ev.write_data;
                        spft_pkg::ADDR_TMOD: tmod = ev.write_data;
                        spft_pkg::ADDR_TL1:  tl1  = ev.write_data;
                        spft_pkg::ADDR_TH1:  th1  = ev.write_data;
                        spft_pkg::ADDR_SBUF: begin
                            upd = 0;
                            sbuf = ev.write_data;
                            tx_byte = ev.write_data;
                            tx_ninth = scon[spft_pkg::SCON_TXBIT9];
                            scon[spft_pkg::SCON_TI] = 1'b0;
                            r.baud_changed = retime();
                            // Start (or restart) the transmit only on a live port.
                            if (period != 0) begin
                                tx_busy = 1;
                                tx_bits_left = frame_bits();
                                accum = 0;
                            end
                        end
                        default: upd = 0;
                    endcase
                    if (upd) r.baud_changed = retime();
                end
                spft_pkg::FUNC_READ: begin
                    case (ev.reg_addr)
                        spft_pkg::ADDR_SCON: r.read_data = scon;
                        spft_pkg::ADDR_PCON: r.read_data = pcon;
                        spft_pkg::ADDR_TCON: r.read_data = tcon;
                        spft_pkg::ADDR_TMOD: r.read_data = tmod;
                        spft_pkg::ADDR_TL1:  r.read_data = tl1;
                        spft_pkg::ADDR_TH1:  r.read_data = th1;
                        spft_pkg::ADDR_SBUF: r.read_data = sbuf;
                        default:             r.read_data = 8'd0;
                    endcase
                end
                spft_pkg::FUNC_RXQ: begin
                    if (period != 0) begin
                        if (rx_waiting) begin
                            overrun = 1;
                        end else begin
                            rx_waiting = 1;
                            rx_byte = ev.rx_byte;
                            rx_ninth = ev.rx_ninth;
                            rx_countdown = period * frame_bits();
                            r.rx_accepted = 1;
                        end
                    end
                end
                default: begin
                    if (period != 0) begin
                        if (!scon[spft_pkg::SCON_RXEN]) rx_waiting = 0;
                        if (tx_busy) begin
                            accum = accum + {16'd0, ev.tick_cycles};
                            while (accum >= period && tx_bits_left > 0) begin
                                accum = accum - period;
                                tx_bits_left = tx_bits_left - 1;
                                if (tx_bits_left == 0) begin
                                    tx_busy = 0;
                                    scon[spft_pkg::SCON_TI] = 1'b1;
                                    r.tx_done = 1;
                                    r.tx_data = tx_byte;
                                    r.tx_ninth = tx_ninth;
                                end
                            end
                            accum = accum & 32'h3FFFF;
                        end
                        if (rx_waiting) begin
                            rx_countdown = (rx_countdown > ev.tick_cycles) ?
                                           rx_countdown - ev.tick_cycles : 0;
                            if (rx_countdown == 0) begin
                                rx_waiting = 0;
                                // Multiprocessor filter drops frames with ninth bit clear.
                                if (!(scon[spft_pkg::SCON_MULTI] && !rx_ninth)) begin
                                    if (scon[spft_pkg::SCON_RI]) begin
                                        overrun = 1;
                                    end else begin
                                        scon[spft_pkg::SCON_RXBIT9] = rx_ninth;
                                        sbuf = rx_byte;
                                        scon[spft_pkg::SCON_RI] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
            r.baud = baud_now;
            r.overrun_flag = overrun;
            if (r.tx_done) tx_frames++;
            if (r.rx_accepted) rx_frames++;
            pending_results.push_back(r);
        endfunction

        function void flag(string what, longint exp_v, longint act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0h, got %0h", what, exp_v, act_v);
        endfunction

        // Compare one accepted result beat with the oldest prediction.
        function void check_beat(port_result_t act);
            port_result_t e;
            results_checked++;
            if (pending_results.size() == 0) begin
                flag("unexpected result beat", 0, act);
                return;
            end
            e = pending_results.pop_front();
            if (act.read_data !== e.read_data)     flag("read_data", e.read_data, act.read_data);
            if (act.rx_accepted !== e.rx_accepted)
                flag("rx_accepted", e.rx_accepted, act.rx_accepted);
            if (act.tx_done !== e.tx_done)         flag("tx_done", e.tx_done, act.tx_done);
            if (act.tx_data !== e.tx_data)         flag("tx_data", e.tx_data, act.tx_data);
            if (act.tx_ninth !== e.tx_ninth)       flag("tx_ninth", e.tx_ninth, act.tx_ninth);
            if (act.baud !== e.baud)               flag("baud", e.baud, act.baud);
            if (act.baud_changed !== e.baud_changed)
                flag("baud_changed", e.baud_changed, act.baud_changed);
            if (act.overrun_flag !== e.overrun_flag)
                flag("overrun", e.overrun_flag, act.overrun_flag);
            if (act.fill !== 3'd0)                 flag("fill bits", 0, act.fill);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // func, reg_addr, write_data, rx_byte, rx_ninth, tick_cycles
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // read_data, rx_accepted, tx_done, tx_data, tx_ninth,
                                 // baud, baud_changed, overrun
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [31:0] cfg_wdata = '0;

    serial_scoreboard sb = new();
    int send_gap_pct = 0;      // chance per beat that the sender idles first
    int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
    int beats_sent = 0;

    serial_port_frame_timing_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Result side: check each accepted beat, then pick the next stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
        m_tready <= (aresetn && $urandom_range(0, 99) >= recv_stall_pct);
    end

    // Drive one event beat; hold it until the handshake completes.
    task automatic send_event(input logic [1:0] func, input logic [7:0] addr,
                              input logic [7:0] wd, input logic [7:0] rb,
                              input logic r9, input logic [15:0] cyc);
        event_beat_t ev;
        ev = '{fill: '0, tick_cycles: cyc, rx_ninth: r9, rx_byte: rb,
               write_data: wd, reg_addr: addr, func: func};
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ev;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(ev);
        beats_sent++;
    endtask

    // Drain all outstanding results, then idle past the longest latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_OSC_HZ) sb.osc_hz = val;
        else sb.cps = val;
    endtask

    // Random event: mostly well-formed port traffic, some noise addresses.
    task automatic send_random();
        logic [7:0] addrs[7];
        logic [7:0] addr, wd;
        logic [15:0] cyc;
        logic [1:0] fn;
        int pick;
        addrs = '{spft_pkg::ADDR_SCON, spft_pkg::ADDR_PCON, spft_pkg::ADDR_TCON,
                  spft_pkg::ADDR_TMOD, spft_pkg::ADDR_TL1, spft_pkg::ADDR_TH1,
                  spft_pkg::ADDR_SBUF};
        addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : addrs[$urandom_range(0, 6)];
        wd = 8'($urandom);
        case (addr)
            // Favor live modes with the receiver enabled.
            spft_pkg::ADDR_SCON:
                if ($urandom_range(0, 9) != 0)
                    wd = wd | 8'h50 ^ 8'($urandom_range(0, 3) << 6) & 8'hC0;
            spft_pkg::ADDR_TCON:
                if ($urandom_range(0, 4) != 0) wd[spft_pkg::TCON_RUN1] = 1'b1;
            spft_pkg::ADDR_TH1:
                if ($urandom_range(0, 3) != 0) wd[7:4] = 4'hF;
            default: ;
        endcase
        pick = $urandom_range(0, 2);
        cyc = (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, (pick == 1) ? 4000 : 300));
        pick = $urandom_range(0, 99);
        if (pick < 30)      fn = spft_pkg::FUNC_WRITE;
        else if (pick < 45) fn = spft_pkg::FUNC_READ;
        else if (pick < 65) fn = spft_pkg::FUNC_RXQ;
        else                fn = spft_pkg::FUNC_TICK;
        send_event(fn, addr, wd, 8'($urandom), 1'($urandom), cyc);
    endtask

    initial begin
        logic [31:0] osc_set[5];
        logic [31:0] cps_set[5];
        int gap_set[5];
        int stall_set[5];
        osc_set   = '{32'd11059200, 32'hFFFF_FFFF, 32'd0, 32'd63, 32'd24000000};
        cps_set   = '{32'd921600, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd2000000};
        gap_set   = '{0, 81, 0, 7, 30};
        stall_set = '{0, 0, 81, 7, 30};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: timer-driven mode 1 transmit and receive paths.
        send_event(spft_pkg::FUNC_READ, 8'h00, 8'h00, 8'h00, 1'b0, 16'd0);      // unknown read
        send_event(spft_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);  // unknown write
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_TCON, 8'h40, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_TH1, 8'hFD, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SCON, 8'h50, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SBUF, 8'hA5, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 16'd100);
        send_event(spft_pkg::FUNC_RXQ, 8'h00, 8'h00, 8'h3C, 1'b1, 16'd0);
        send_event(spft_pkg::FUNC_RXQ, 8'h00, 8'h00, 8'hC3, 1'b0, 16'd0);  // already pending
        send_event(spft_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF);
        send_event(spft_pkg::FUNC_READ, spft_pkg::ADDR_SBUF, 8'h00, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_RXQ, 8'h00, 8'h00, 8'h11, 1'b1, 16'd0);
        send_event(spft_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF);  // RI still set
        // Mode 2: filter, restart while busy, receiver disabled.
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SCON, 8'hB0, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_RXQ, 8'h00, 8'h00, 8'h77, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SCON, 8'h88, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SBUF, 8'h5A, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SBUF, 8'h00, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_RXQ, 8'h00, 8'h00, 8'hFF, 1'b1, 16'd0);
        send_event(spft_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_PCON, 8'h80, 8'h00, 1'b0, 16'd0);
        // Timer off in mode 1, then transmit and receive on a dead port.
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SCON, 8'h40, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_TCON, 8'h00, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_SBUF, 8'h33, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_RXQ, 8'h00, 8'h00, 8'h44, 1'b1, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_TMOD, 8'h20, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_WRITE, spft_pkg::ADDR_TL1, 8'hFF, 8'h00, 1'b0, 16'd0);
        send_event(spft_pkg::FUNC_READ, spft_pkg::ADDR_SCON, 8'h00, 8'h00, 1'b0, 16'd0);
        drain();   // hold the sender until every result is back

        // Random phases, each under its own clock settings and idling pattern.
        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(CFG_OSC_HZ, osc_set[ph]);
            write_cfg(CFG_CPS, cps_set[ph]);
            send_gap_pct   = gap_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int i = 0; i < 86; i++) send_random();
            drain();
        end

        $display("Covered %0d event beats and %0d result beats: %0d transmit frames done,",
                 beats_sent, sb.results_checked, sb.tx_frames);
        $display("%0d receive frames accepted, five clock settings and five idling patterns.",
                 sb.rx_frames);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
